// File: rtl/ubs_pkg.sv
package ubs_pkg;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } in_item_t;

    // Output transfer payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Decision on the byte at the head of the queue
    localparam logic [1:0] CLS_SINGLE = 2'd0;
    localparam logic [1:0] CLS_PASS   = 2'd1;
    localparam logic [1:0] CLS_REPL   = 2'd2;
    localparam logic [1:0] CLS_HOLD   = 2'd3;

    // Source of the next output byte
    localparam logic [1:0] SEL_HEAD = 2'd0;
    localparam logic [1:0] SEL_EF   = 2'd1;
    localparam logic [1:0] SEL_BF   = 2'd2;
    localparam logic [1:0] SEL_BD   = 2'd3;

    // Replacement character bytes
    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    // Queue depth: three held bytes plus the new one
    localparam int unsigned QUEUE_DEPTH = 4;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       pop;
        logic       emit;
        logic [1:0] byte_sel;
        logic       set_rep_last;
        logic       pass_load;
        logic       pass_dec;
    } ubs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic       len_zero;
        logic [1:0] head_class;
        logic       pass_done;
        logic       out_free;
    } ubs_sts_t;

    // Sequence length from the lead byte; zero marks an invalid lead
    function automatic logic [2:0] seq_length(input logic [7:0] c);
        logic [2:0] n;
        if (c <= 8'h7F) begin
            n = 3'd1;
        end else if (c >= 8'hC0 && c <= 8'hDF) begin
            n = 3'd2;
        end else if (c >= 8'hE0 && c <= 8'hEF) begin
            n = 3'd3;
        end else if (c >= 8'hF0 && c <= 8'hF7) begin
            n = 3'd4;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage

// File: rtl/ubs_datapath.sv
module ubs_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  ubs_pkg::in_item_t  s_data,
    input  ubs_pkg::ubs_cmd_t  cmd,
    output ubs_pkg::ubs_sts_t  sts,
    output logic               m_valid,
    input  logic               m_ready,
    output ubs_pkg::out_item_t m_data
);

    logic [7:0]         buf_reg [ubs_pkg::QUEUE_DEPTH];
    logic [2:0]         len_reg;
    logic [2:0]         len_next;
    logic               eos_reg;
    logic               rep_last_reg;
    logic [1:0]         pass_cnt_reg;
    logic               m_valid_reg;
    ubs_pkg::out_item_t out_reg;

    logic [2:0] need;
    logic       cont_ok;
    logic [1:0] head_class;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       head_last;

    // Classify the head byte against the bytes queued behind it
    always_comb begin
        need    = ubs_pkg::seq_length(buf_reg[0]);
        cont_ok = 1'b1;
        for (int k = 1; k < ubs_pkg::QUEUE_DEPTH; k++) begin
            if (3'(k) < need && buf_reg[k][7:6] != 2'b10) begin
                cont_ok = 1'b0;
            end
        end
        if (need == 3'd1) begin
            head_class = ubs_pkg::CLS_SINGLE;
        end else if (need == 3'd0) begin
            head_class = ubs_pkg::CLS_REPL;
        end else if (len_reg < need) begin
            head_class = eos_reg ? ubs_pkg::CLS_REPL : ubs_pkg::CLS_HOLD;
        end else if (cont_ok) begin
            head_class = ubs_pkg::CLS_PASS;
        end else begin
            head_class = ubs_pkg::CLS_REPL;
        end
    end

    // Last output of a string is the final byte leaving the queue
    assign head_last = eos_reg && (len_reg == 3'd1);

    // Select the outgoing byte
    always_comb begin
        case (cmd.byte_sel)
            ubs_pkg::SEL_HEAD: begin
                emit_byte = buf_reg[0];
                emit_last = head_last;
            end
            ubs_pkg::SEL_EF: begin
                emit_byte = ubs_pkg::REPL_B0;
                emit_last = 1'b0;
            end
            ubs_pkg::SEL_BF: begin
                emit_byte = ubs_pkg::REPL_B1;
                emit_last = 1'b0;
            end
            default: begin
                emit_byte = ubs_pkg::REPL_B2;
                emit_last = rep_last_reg;
            end
        endcase
    end

    assign sts.len_zero   = (len_reg == 3'd0);
    assign sts.head_class = head_class;
    assign sts.pass_done  = (pass_cnt_reg == 2'd1);
    assign sts.out_free   = !m_valid_reg || m_ready;

    // Queue fill level
    always_comb begin
        len_next = len_reg;
        if (cmd.load) begin
            len_next = len_reg + 3'd1;
        end else if (cmd.pop) begin
            len_next = len_reg - 3'd1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Queue contents: append on load, shift toward the head on pop
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            buf_reg[len_reg[1:0]] <= s_data.data_byte;
            eos_reg               <= s_data.end_of_string;
        end else if (cmd.pop) begin
            for (int k = 0; k < ubs_pkg::QUEUE_DEPTH - 1; k++) begin
                buf_reg[k] <= buf_reg[k + 1];
            end
        end
    end

    // Replacement end flag and pass-through counter
    always_ff @(posedge aclk) begin
        if (cmd.set_rep_last) begin
            rep_last_reg <= head_last;
        end
        if (cmd.pass_load) begin
            pass_cnt_reg <= 2'(need - 3'd1);
        end else if (cmd.pass_dec) begin
            pass_cnt_reg <= pass_cnt_reg - 2'd1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.out_byte <= emit_byte;
            out_reg.out_last <= emit_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/ubs_ctrl.sv
module ubs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ubs_pkg::ubs_sts_t sts,
    output ubs_pkg::ubs_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_REP1 = 3'd2;
    localparam logic [2:0] ST_REP2 = 3'd3;
    localparam logic [2:0] ST_PASS = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Sequence accept, classify and emit steps
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.byte_sel = ubs_pkg::SEL_HEAD;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (sts.len_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    unique case (sts.head_class)
                        ubs_pkg::CLS_HOLD: begin
                            state_next = ST_IDLE;
                        end
                        ubs_pkg::CLS_SINGLE: begin
                            if (sts.out_free) begin
                                cmd.emit = 1'b1;
                                cmd.pop  = 1'b1;
                            end
                        end
                        ubs_pkg::CLS_PASS: begin
                            if (sts.out_free) begin
                                cmd.emit      = 1'b1;
                                cmd.pop       = 1'b1;
                                cmd.pass_load = 1'b1;
                                state_next    = ST_PASS;
                            end
                        end
                        default: begin
                            if (sts.out_free) begin
                                cmd.emit         = 1'b1;
                                cmd.byte_sel     = ubs_pkg::SEL_EF;
                                cmd.pop          = 1'b1;
                                cmd.set_rep_last = 1'b1;
                                state_next       = ST_REP1;
                            end
                        end
                    endcase
                end
            end
            ST_REP1: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.byte_sel = ubs_pkg::SEL_BF;
                    state_next   = ST_REP2;
                end
            end
            ST_REP2: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.byte_sel = ubs_pkg::SEL_BD;
                    state_next   = ST_EVAL;
                end
            end
            ST_PASS: begin
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.pop      = 1'b1;
                    cmd.pass_dec = 1'b1;
                    if (sts.pass_done) begin
                        state_next = ST_EVAL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/utf8_byte_sanitizer.sv
// Repairs a byte stream into loosely valid UTF-8. Bytes 00-7F pass; a lead byte
// is held until its continuation bytes arrive and the whole sequence passes if
// they are all 10xxxxxx. A bad or stray byte, or a lead cut off by end_of_string,
// becomes EF BF BD and the bytes behind it are examined again. Overlong forms and
// surrogates are not rejected. out_last marks the final output byte of a string.
// One input byte is taken at a time: the sequencer accepts it, emits each output
// byte it produces, and finds the queue empty or a sequence still incomplete
// before it takes the next; m_ready held low stalls each output byte in turn.
// All output bytes leave through a single output register driven by one
// sequencer, which paces the input.
module utf8_byte_sanitizer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ubs_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ubs_pkg::out_item_t m_data
);

    ubs_pkg::ubs_cmd_t cmd;
    ubs_pkg::ubs_sts_t sts;

    // Sequencer
    ubs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Byte queue, classifier and output register
    ubs_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    ubs_pkg::in_item_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    ubs_pkg::out_item_t m_data;

    // Expected output bytes, oldest first
    ubs_pkg::out_item_t sanitized_q [$];
    // Predictor copy of the unfinished sequence
    logic [7:0] pend_bytes [0:2];
    int         pend_cnt = 0;

    int mismatches   = 0;
    int stall_cycles = 0;
    bit src_idle     = 1'b1;
    bit dst_idle     = 1'b1;
    bit hold_req     = 1'b0;

    utf8_byte_sanitizer uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Sequence length implied by a lead byte; zero for a byte that cannot start one
    function automatic int utf8_span(input logic [7:0] c);
        if (c <= 8'h7F) return 1;
        if (c >= 8'hC0 && c <= 8'hDF) return 2;
        if (c >= 8'hE0 && c <= 8'hEF) return 3;
        if (c >= 8'hF0 && c <= 8'hF7) return 4;
        return 0;
    endfunction

    // Work out the bytes one accepted input causes and queue them
    function automatic void sanitize_byte(input ubs_pkg::in_item_t it);
        logic [7:0]         work_b [0:3];
        logic [7:0]         repl_seq [0:2];
        ubs_pkg::out_item_t fresh [$];
        ubs_pkg::out_item_t o;
        int                 len, p, need, k, take;
        bit                 repl;
        repl_seq[0] = ubs_pkg::REPL_B0;
        repl_seq[1] = ubs_pkg::REPL_B1;
        repl_seq[2] = ubs_pkg::REPL_B2;
        for (k = 0; k < pend_cnt; k++) begin
            work_b[k] = pend_bytes[k];
        end
        work_b[pend_cnt] = it.data_byte;
        len = pend_cnt + 1;
        pend_cnt = 0;
        p = 0;
        while (p < len) begin
            need = utf8_span(work_b[p]);
            repl = 1'b0;
            take = 1;
            if (need == 0) begin
                repl = 1'b1;
            end else if (need > 1 && len - p < need) begin
                // hold an incomplete sequence unless the string ends here
                if (!it.end_of_string) begin
                    for (k = 0; p + k < len && k < 3; k++) begin
                        pend_bytes[k] = work_b[p + k];
                    end
                    pend_cnt = k;
                    break;
                end
                repl = 1'b1;
            end else if (need > 1) begin
                take = need;
                for (k = 1; k < need; k++) begin
                    if (work_b[p + k][7:6] != 2'b10) begin
                        repl = 1'b1;
                    end
                end
            end
            o.out_last = 1'b0;
            if (repl) begin
                for (k = 0; k < 3; k++) begin
                    o.out_byte = repl_seq[k];
                    fresh = {fresh, o};
                end
                p = p + 1;
            end else begin
                for (k = 0; k < take; k++) begin
                    o.out_byte = work_b[p + k];
                    fresh = {fresh, o};
                end
                p = p + take;
            end
        end
        if (it.end_of_string && fresh.size() > 0) begin
            fresh[fresh.size() - 1].out_last = 1'b1;
        end
        sanitized_q = {sanitized_q, fresh};
    endfunction

    // Offer one byte after a random gap and predict its output once transferred
    task automatic send_byte(input logic [7:0] b, input logic eos);
        ubs_pkg::in_item_t item;
        int                gap;
        item.data_byte     = b;
        item.end_of_string = eos;
        gap = src_idle ? $urandom_range(0, 11) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sanitize_byte(item);
    endtask

    // Drop valid right after the last transfer of a burst
    task automatic stop_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sanitized_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_lead(input int span);
        case (span)
            2:       return 8'($urandom_range(8'hC0, 8'hDF));
            3:       return 8'($urandom_range(8'hE0, 8'hEF));
            default: return 8'($urandom_range(8'hF0, 8'hF7));
        endcase
    endfunction

    task automatic test_plain_ascii();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // Leads of each length (C2, EF, F7) with edge continuation bytes
    task automatic test_valid_sequences();
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Stray continuation bytes and bytes that can never lead
    task automatic test_stray_bytes();
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Lead followed by a non-continuation byte: replace the lead, rescan the rest
    task automatic test_broken_sequences();
        send_byte(8'hE0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
    endtask

    // String ends inside a sequence
    task automatic test_cut_by_end();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hC0, 1'b1);
        send_byte(8'hDF, 1'b1);
    endtask

    // Stall the output for a long stretch while the input keeps offering bytes
    task automatic test_backpressure();
        int k;
        src_idle = 1'b0;
        stop_input();
        wait_drained();
        hold_req = 1'b1;
        for (k = 0; k < 40; k++) begin
            if (k % 8 == 7) begin
                send_byte(8'($urandom_range(0, 127)), 1'b0);
            end else begin
                send_byte(8'($urandom_range(8'h80, 8'hBF)), k == 39);
            end
        end
        src_idle = 1'b1;
    endtask

    // Mostly well-formed text with random content, mixed with broken and noise bytes
    task automatic test_random_text(input int n_items, input bit src_gaps, input bit dst_gaps);
        logic [7:0] grp [$];
        int         sent, kind, span, cut, k;
        bit         force_end, eos;
        src_idle = src_gaps;
        dst_idle = dst_gaps;
        sent = 0;
        while (sent < n_items) begin
            grp.delete();
            force_end = 1'b0;
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                grp = {grp, 8'($urandom_range(0, 127))};
            end else if (kind <= 5) begin
                span = $urandom_range(2, 4);
                grp = {grp, pick_lead(span)};
                for (k = 1; k < span; k++) begin
                    grp = {grp, 8'($urandom_range(8'h80, 8'hBF))};
                end
            end else if (kind == 6) begin
                span = $urandom_range(2, 4);
                cut  = $urandom_range(0, span - 2);
                grp = {grp, pick_lead(span)};
                for (k = 0; k < cut; k++) begin
                    grp = {grp, 8'($urandom_range(8'h80, 8'hBF))};
                end
                if ($urandom_range(0, 1)) begin
                    grp = {grp, ($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                                      : 8'($urandom_range(8'hC0, 8'hFF)))};
                end else begin
                    force_end = 1'b1;
                end
            end else if (kind == 7) begin
                grp = {grp, ($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hF8, 8'hFF)))};
            end else begin
                grp = {grp, 8'($urandom_range(0, 255))};
            end
            foreach (grp[i]) begin
                if (i == grp.size() - 1) begin
                    eos = force_end || ($urandom_range(0, 5) == 0);
                end else begin
                    eos = ($urandom_range(0, 39) == 0);
                end
                send_byte(grp[i], eos);
                sent++;
            end
        end
        src_idle = 1'b1;
        dst_idle = 1'b1;
    endtask

    // Output side: random stall per byte, or one long hold-off on request
    initial begin : result_sink
        int w;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                w = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                w = dst_idle ? $urandom_range(0, 11) : 0;
            end
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Compare each output transfer with the oldest expected byte
    always @(posedge aclk) begin
        ubs_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sanitized_q.size() == 0) begin
                $display("%0t: unexpected output: expected none, got byte %02h last %0b",
                         $time, m_data.out_byte, m_data.out_last);
                mismatches++;
            end else begin
                want = sanitized_q.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, want.out_byte, m_data.out_byte);
                    mismatches++;
                end
                if (m_data.out_last !== want.out_last) begin
                    $display("%0t: out_last mismatch: expected %0b, got %0b",
                             $time, want.out_last, m_data.out_last);
                    mismatches++;
                end
            end
        end
    end

    // Abort when no transfer happens on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_plain_ascii();
        test_valid_sequences();
        test_stray_bytes();
        test_broken_sequences();
        test_cut_by_end();
        test_backpressure();
        test_random_text(50, 1'b1, 1'b1);
        test_random_text(45, 1'b0, 1'b0);
        test_random_text(45, 1'b1, 1'b0);
        test_random_text(45, 1'b0, 1'b1);

        // Drain and give late extra bytes a chance to show up
        stop_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/ubs_pkg.sv
rtl/ubs_datapath.sv
rtl/ubs_ctrl.sv
rtl/utf8_byte_sanitizer.sv
bench/tb.sv
